### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Defining NO_ASSERTIONS removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a condition in one cycle implies another in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

### sv/bfa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap allocator package
// Types, command codes and sizes shared by the allocator modules.
// ----------------------------------------------------------------------------
package bfa_pkg;

   localparam int NUM_BLOCKS   = 64;
   localparam int QUEUE_DEPTH  = 2;

   localparam int CMD_W        = 2;
   localparam int START_W      = 6;
   localparam int COUNT_W      = 7;
   // Scan position runs from 0 up to and including NUM_BLOCKS.
   localparam int IDX_W        = $clog2(NUM_BLOCKS + 1);

   localparam logic [CMD_W-1:0] CMD_MARK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [START_W-1:0] start_block;
      logic [COUNT_W-1:0] block_count;
   } req_type;

   typedef struct packed {
      logic [START_W-1:0] run_start;
      logic [COUNT_W-1:0] run_length;
      logic               found;
      logic               last;
      logic               range_error;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_SET,
      OP_CLEAR,
      OP_FIND,
      OP_ACK,
      OP_ERROR
   } op_kind_type;

   typedef struct packed {
      op_kind_type            op;
      logic [NUM_BLOCKS-1:0]  mask;
      logic [COUNT_W-1:0]     need;
   } job_type;

   typedef struct packed {
      logic has_item;
      logic has_room;
   } queue_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

endpackage

### sv/bfa_front.sv
// ----------------------------------------------------------------------------
// Allocator front end
// Accepts requests, checks ranges against the map and builds block masks.
// ----------------------------------------------------------------------------
module bfa_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  bfa_pkg::req_type          req_data,
   input  bfa_pkg::queue_status_type q_status,
   output logic                      push,
   output bfa_pkg::job_type          job
);

   logic [bfa_pkg::COUNT_W:0]      range_end;
   logic                           out_of_range;
   logic [bfa_pkg::NUM_BLOCKS-1:0] low_ones;

   assign req_stall = !q_status.has_room;
   assign push      = req_valid && q_status.has_room;

   assign range_end    = {2'b00, req_data.start_block} + {1'b0, req_data.block_count};
   assign out_of_range = range_end > (bfa_pkg::COUNT_W + 1)'(bfa_pkg::NUM_BLOCKS);

   // A shift by the full map width leaves no ones, so a full-map range works.
   assign low_ones = ~({bfa_pkg::NUM_BLOCKS{1'b1}} << req_data.block_count);

   always_comb begin
      job.mask = low_ones << req_data.start_block;
      job.need = req_data.block_count;
      unique case (req_data.command)
         bfa_pkg::CMD_MARK: begin
            job.op = out_of_range ? bfa_pkg::OP_ERROR : bfa_pkg::OP_SET;
         end
         bfa_pkg::CMD_FREE: begin
            job.op = out_of_range ? bfa_pkg::OP_ERROR : bfa_pkg::OP_CLEAR;
         end
         bfa_pkg::CMD_FIND: begin
            job.op = bfa_pkg::OP_FIND;
         end
         default: begin
            job.op = bfa_pkg::OP_ACK;
         end
      endcase
   end

endmodule

### sv/bfa_queue.sv
// ----------------------------------------------------------------------------
// Allocator job queue
// Short first-in first-out buffer between the front end and the engine.
// ----------------------------------------------------------------------------
module bfa_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  bfa_pkg::job_type          push_data,
   input  logic                      pop,
   output bfa_pkg::job_type          head,
   output bfa_pkg::queue_status_type status
);

   localparam int PTR_W = (bfa_pkg::QUEUE_DEPTH > 1) ? $clog2(bfa_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(bfa_pkg::QUEUE_DEPTH + 1);

   bfa_pkg::job_type entries_ff [bfa_pkg::QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign status.has_item = count_ff != '0;
   assign status.has_room = count_ff != CNT_W'(bfa_pkg::QUEUE_DEPTH);
   assign do_push         = push && status.has_room;
   assign do_pop          = pop && status.has_item;
   assign head            = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(bfa_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(bfa_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/bfa_engine.sv
// ----------------------------------------------------------------------------
// Allocator engine
// Holds the allocation map, applies range updates and scans for free runs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfa_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  bfa_pkg::queue_status_type q_status,
   input  bfa_pkg::job_type          job,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output bfa_pkg::rsp_type          rsp_data
);

   bfa_pkg::state_type state_ff, state_in;

   logic [bfa_pkg::NUM_BLOCKS-1:0] map_ff, map_in;
   logic [bfa_pkg::NUM_BLOCKS-1:0] scan_ff, scan_in;
   logic [bfa_pkg::IDX_W-1:0]      idx_ff, idx_in;
   logic [bfa_pkg::COUNT_W-1:0]    need_ff, need_in;
   logic                           in_run_ff, in_run_in;
   logic [bfa_pkg::START_W-1:0]    run_begin_ff, run_begin_in;
   logic [bfa_pkg::COUNT_W-1:0]    run_len_ff, run_len_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic [bfa_pkg::START_W-1:0]    pend_start_ff, pend_start_in;
   logic [bfa_pkg::COUNT_W-1:0]    pend_len_ff, pend_len_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   bfa_pkg::rsp_type               rsp_ff, rsp_in;

   logic             out_free;
   logic             scan_end;
   logic             cur_free;
   logic             run_closes;
   logic             emit;
   bfa_pkg::rsp_type emit_data;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign scan_end   = idx_ff == bfa_pkg::IDX_W'(bfa_pkg::NUM_BLOCKS);
   // Past the end of the map the scan sees an allocated block, closing any open run.
   assign cur_free   = !scan_end && !scan_ff[0];
   assign run_closes = !cur_free && in_run_ff && (run_len_ff >= need_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfa_pkg::ST_IDLE: begin
            if (q_status.has_item && out_free && job.op == bfa_pkg::OP_FIND) begin
               state_in = bfa_pkg::ST_SCAN;
            end
         end
         bfa_pkg::ST_SCAN: begin
            if (out_free && scan_end) begin
               state_in = bfa_pkg::ST_FLUSH;
            end
         end
         bfa_pkg::ST_FLUSH: begin
            if (out_free) begin
               state_in = bfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfa_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs
   always_comb begin
      pop           = 1'b0;
      emit          = 1'b0;
      emit_data     = '0;
      map_in        = map_ff;
      scan_in       = scan_ff;
      idx_in        = idx_ff;
      need_in       = need_ff;
      in_run_in     = in_run_ff;
      run_begin_in  = run_begin_ff;
      run_len_in    = run_len_ff;
      pend_valid_in = pend_valid_ff;
      pend_start_in = pend_start_ff;
      pend_len_in   = pend_len_ff;
      unique case (state_ff)
         bfa_pkg::ST_IDLE: begin
            if (q_status.has_item && out_free) begin
               pop            = 1'b1;
               emit_data.last = 1'b1;
               case (job.op)
                  bfa_pkg::OP_SET: begin
                     map_in = map_ff | job.mask;
                     emit   = 1'b1;
                  end
                  bfa_pkg::OP_CLEAR: begin
                     map_in = map_ff & ~job.mask;
                     emit   = 1'b1;
                  end
                  bfa_pkg::OP_ERROR: begin
                     emit                  = 1'b1;
                     emit_data.range_error = 1'b1;
                  end
                  bfa_pkg::OP_FIND: begin
                     scan_in       = map_ff;
                     idx_in        = '0;
                     need_in       = job.need;
                     in_run_in     = 1'b0;
                     run_len_in    = '0;
                     pend_valid_in = 1'b0;
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         bfa_pkg::ST_SCAN: begin
            if (out_free) begin
               scan_in = scan_ff >> 1;
               // The index parks at the end of the map until the next find.
               if (!scan_end) begin
                  idx_in = idx_ff + 1'b1;
               end
               if (cur_free) begin
                  in_run_in = 1'b1;
                  if (!in_run_ff) begin
                     run_begin_in = idx_ff[bfa_pkg::START_W-1:0];
                     run_len_in   = bfa_pkg::COUNT_W'(1);
                  end else begin
                     run_len_in = run_len_ff + 1'b1;
                  end
               end else begin
                  in_run_in  = 1'b0;
                  run_len_in = '0;
               end
               // A closed run is held back until the next run closes, so that the final one can carry last.
               if (run_closes) begin
                  if (pend_valid_ff) begin
                     emit                 = 1'b1;
                     emit_data.found      = 1'b1;
                     emit_data.run_start  = pend_start_ff;
                     emit_data.run_length = pend_len_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_start_in = run_begin_ff;
                  pend_len_in   = run_len_ff;
               end
            end
         end
         bfa_pkg::ST_FLUSH: begin
            if (out_free) begin
               emit           = 1'b1;
               emit_data.last = 1'b1;
               if (pend_valid_ff) begin
                  emit_data.found      = 1'b1;
                  emit_data.run_start  = pend_start_ff;
                  emit_data.run_length = pend_len_ff;
               end
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bfa_pkg::ST_IDLE;
         map_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         in_run_ff     <= 1'b0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         map_ff        <= map_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         in_run_ff     <= in_run_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      need_ff       <= need_in;
      run_begin_ff  <= run_begin_in;
      run_len_ff    <= run_len_in;
      pend_start_ff <= pend_start_in;
      pend_len_ff   <= pend_len_in;
      rsp_ff        <= rsp_in;
   end

   `ASSERT_IMPLIES(a_pop_idle, clock, reset, pop,
      state_ff == bfa_pkg::ST_IDLE, "job taken outside idle")
   `ASSERT_HOLDS(a_idx_bound, clock, reset,
      idx_ff <= bfa_pkg::IDX_W'(bfa_pkg::NUM_BLOCKS), "scan index past end of map")
   `ASSERT_IMPLIES(a_found_len, clock, reset, rsp_valid_ff && rsp_ff.found,
      rsp_ff.run_length != '0 && !rsp_ff.range_error, "found result with empty run")
   `ASSERT_NEXT(a_flush_last, clock, reset, state_ff == bfa_pkg::ST_FLUSH && out_free,
      state_ff == bfa_pkg::ST_IDLE && rsp_valid_ff && rsp_ff.last,
      "find did not end with last")

endmodule

### sv/bitmap_free_run_allocator.sv
// Mark, free and unused commands: the result is registered in the cycle after the job
// leaves the queue; one such item per cycle is sustained while no find runs and the
// result channel does not stall. Find: the engine walks the map one block per cycle
// while the result channel does not stall and takes no new job until the find ends.
// The two-entry job queue lets requests be accepted while a find scan runs.
// Synchronous reset frees every block and empties the queue and output register.
// ----------------------------------------------------------------------------
// Bitmap free-run allocator
// Allocation bitmap with range mark/free and a scan for free runs.
// ----------------------------------------------------------------------------
module bitmap_free_run_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bfa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bfa_pkg::rsp_type rsp_data
);

   bfa_pkg::queue_status_type q_status;
   bfa_pkg::job_type          front_job;
   bfa_pkg::job_type          head_job;
   logic                      push;
   logic                      pop;

   bfa_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .job       (front_job)
   );

   bfa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_job),
      .pop       (pop),
      .head      (head_job),
      .status    (q_status)
   );

   bfa_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .job       (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
